[rtl/bsm_pkg.sv]
// Shared types and constants for the breakpoint sort and merge block.
`default_nettype none

package bsm_pkg;

    localparam int POS_W     = 32;
    localparam int SEG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EPS_MIXED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_SIDE  = 2'd1;

    localparam logic [POS_W-1:0] EPS_RESET = 32'd16;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             kind;
        logic             last_point;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] point_position;
        logic             point_kind;
        logic             last_out;
        logic [SEG_W-1:0] segment_count;
        logic             overflow;
    } t_out;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             kind;
    } t_point;

    typedef struct packed {
        logic load;
        logic key_rd;
        logic key_cap;
        logic sort_shift;
        logic sort_insert;
        logic merge_init;
        logic merge_cur;
        logic merge_step;
        logic merge_flush;
        logic emit_rd;
        logic list_clear;
    } t_cmd;

    typedef struct packed {
        logic sort_done;
        logic shift;
        logic last_zero;
        logic k_last;
        logic e_last;
    } t_stat;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SKEY   = 10'b00_0000_0010,
        ST_SLOAD  = 10'b00_0000_0100,
        ST_SCMP   = 10'b00_0000_1000,
        ST_MRD0   = 10'b00_0001_0000,
        ST_MCUR   = 10'b00_0010_0000,
        ST_MNXT   = 10'b00_0100_0000,
        ST_MFLUSH = 10'b00_1000_0000,
        ST_EMIT   = 10'b01_0000_0000,
        ST_END    = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

[rtl/breakpoint_sort_and_merge_top.sv]
// Top level of the breakpoint sort and merge block.
`default_nettype none

// Points are loaded one per transaction while busy is low. The transaction
// with last_point set starts processing and raises busy. For n stored points before the final
// one (n = fill count, at most MAX_POINTS - 1), the insertion sort takes each inner key in turn
// and moves it one place per step, all bound by the single read and single write port of the
// point memory. The merge scan follows. After the first memory read, which is registered,
// the m survivors appear on consecutive cycles, one per o_strobe, and busy falls in the
// cycle after the last one.
// Results cannot be held off by the receiver; they must be taken in the cycle they appear.
// Configuration writes are always accepted and must be issued only while busy is low.

module breakpoint_sort_and_merge_top
    import bsm_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire t_in                  i_item,
    output logic                      busy,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [POS_W-1:0]     i_cfg_data,
    output logic                      o_strobe,
    output t_out                      o_result
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    bsm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_item.last_point),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (ctrl_busy)
    );

    bsm_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = 1'b1;

    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("Result strobe outside a busy period.");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_out) |=> !o_strobe)
        else $error("Result strobe after the final result of a burst.");

    a_plain_point_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.last_point) |=> !busy)
        else $error("A non-final point started processing.");

    a_final_point_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last_point) |=> busy)
        else $error("The final point did not start processing.");

endmodule

`default_nettype wire

[rtl/bsm_ctrl.sv]
// Controller state machine that sequences loading, sorting, merging and emitting.
`default_nettype none

module bsm_ctrl
    import bsm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_last_point,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_point) begin
                        n_state = ST_SKEY;
                    end
                end
            end
            ST_SKEY: begin
                if (i_stat.sort_done) begin
                    n_state = ST_MRD0;
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = ST_SLOAD;
                end
            end
            ST_SLOAD: begin
                o_cmd.key_cap = 1'b1;
                n_state       = ST_SCMP;
            end
            ST_SCMP: begin
                if (i_stat.shift) begin
                    o_cmd.sort_shift = 1'b1;
                end else begin
                    o_cmd.sort_insert = 1'b1;
                    n_state           = ST_SKEY;
                end
            end
            ST_MRD0: begin
                o_cmd.merge_init = 1'b1;
                n_state          = ST_MCUR;
            end
            ST_MCUR: begin
                o_cmd.merge_cur = 1'b1;
                n_state         = i_stat.last_zero ? ST_MFLUSH : ST_MNXT;
            end
            ST_MNXT: begin
                o_cmd.merge_step = 1'b1;
                if (i_stat.k_last) begin
                    n_state = ST_MFLUSH;
                end
            end
            ST_MFLUSH: begin
                o_cmd.merge_flush = 1'b1;
                n_state           = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_stat.e_last) begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                o_cmd.list_clear = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Controller state is not one-hot.");

    a_scan_ends_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MNXT && i_stat.k_last) |=> (r_state == ST_MFLUSH))
        else $error("Merge scan did not end in a flush.");

    a_emit_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_stat.e_last) |=> (r_state == ST_END))
        else $error("Emit pass did not finish after the last survivor.");

endmodule

`default_nettype wire

[rtl/bsm_dpath.sv]
// Datapath with the point memory, sort and merge counters, thresholds and result register.
`default_nettype none

module bsm_dpath
    import bsm_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire t_in                  i_item,
    input  wire logic                 i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [POS_W-1:0]     i_cfg_data,
    output t_stat                     o_stat,
    output logic                      o_strobe,
    output t_out                      o_result
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_POINTS - 1);

    t_point r_mem [MAX_POINTS];
    t_point r_rd;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_point        wr_data;

    logic [AW-1:0] r_fill, r_last, r_j, r_i, r_k, r_w, r_e;
    logic [AW-1:0] n_fill, n_last, n_j, n_i, n_k, n_w, n_e;
    logic          r_ovf, r_vld, r_efirst, r_elast;
    logic          n_ovf, n_vld, n_efirst, n_elast;

    t_point           r_key, r_cur;
    t_point           n_key, n_cur;
    logic [POS_W-1:0] r_first_pos, r_end_pos;
    logic [POS_W-1:0] n_first_pos, n_end_pos;
    logic [POS_W-1:0] r_eps_mixed, r_eps_side;

    logic             load_wr;
    logic [POS_W:0]   gap;
    logic [POS_W-1:0] thr;
    logic             close;

    assign load_wr = i_item.last_point || (r_fill != LAST_SLOT);
    assign gap     = {1'b0, r_rd.pos} - {1'b0, r_cur.pos};
    assign thr     = (r_cur.kind && r_rd.kind) ? r_eps_side : r_eps_mixed;
    assign close   = gap[POS_W] || (gap[POS_W-1:0] < thr);

    assign o_stat.sort_done = (r_j >= r_last);
    assign o_stat.shift     = (r_i != '0) && (r_rd.pos > r_key.pos);
    assign o_stat.last_zero = (r_last == '0);
    assign o_stat.k_last    = (r_k == r_last);
    assign o_stat.e_last    = (r_e == r_w);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill;
        wr_data = r_cur;
        rd_addr = '0;
        if (i_cmd.load) begin
            wr_en   = load_wr;
            wr_addr = r_fill;
            wr_data = '{pos: i_item.position, kind: i_item.kind};
        end
        if (i_cmd.key_rd) begin
            rd_addr = r_j;
        end
        if (i_cmd.key_cap) begin
            rd_addr = r_j - 1'b1;
        end
        if (i_cmd.sort_shift) begin
            wr_en   = 1'b1;
            wr_addr = r_i + 1'b1;
            wr_data = r_rd;
            rd_addr = r_i - 1'b1;
        end
        if (i_cmd.sort_insert) begin
            wr_en   = 1'b1;
            wr_addr = r_i + 1'b1;
            wr_data = r_key;
        end
        if (i_cmd.merge_cur) begin
            rd_addr = r_k;
        end
        if (i_cmd.merge_step) begin
            wr_en   = !close;
            wr_addr = r_w;
            wr_data = r_cur;
            rd_addr = o_stat.k_last ? r_k : r_k + 1'b1;
        end
        if (i_cmd.merge_flush) begin
            wr_en   = 1'b1;
            wr_addr = r_w;
            wr_data = r_cur;
        end
        if (i_cmd.emit_rd) begin
            rd_addr = r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_fill      = r_fill;
        n_last      = r_last;
        n_j         = r_j;
        n_i         = r_i;
        n_k         = r_k;
        n_w         = r_w;
        n_e         = r_e;
        n_ovf       = r_ovf;
        n_key       = r_key;
        n_cur       = r_cur;
        n_first_pos = r_first_pos;
        n_end_pos   = r_end_pos;
        n_vld       = i_cmd.emit_rd;
        n_efirst    = (r_e == '0);
        n_elast     = (r_e == r_w);
        if (i_cmd.load) begin
            if (load_wr && (r_fill == '0)) begin
                n_first_pos = i_item.position;
            end
            if (i_item.last_point) begin
                n_last    = r_fill;
                n_j       = AW'(2);
                n_end_pos = i_item.position;
            end else if (r_fill != LAST_SLOT) begin
                n_fill = r_fill + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.key_cap) begin
            n_key = r_rd;
            n_i   = r_j - 1'b1;
        end
        if (i_cmd.sort_shift) begin
            n_i = r_i - 1'b1;
        end
        if (i_cmd.sort_insert) begin
            n_j = r_j + 1'b1;
        end
        if (i_cmd.merge_init) begin
            n_k = AW'(1);
            n_w = '0;
        end
        if (i_cmd.merge_cur) begin
            n_cur = r_rd;
        end
        if (i_cmd.merge_step) begin
            if (!close) begin
                n_w   = r_w + 1'b1;
                n_cur = r_rd;
            end else if (!r_cur.kind && r_rd.kind) begin
                n_cur.pos = r_rd.pos;
            end
            if (!o_stat.k_last) begin
                n_k = r_k + 1'b1;
            end
        end
        if (i_cmd.merge_flush) begin
            n_e = '0;
        end
        if (i_cmd.emit_rd) begin
            n_e = r_e + 1'b1;
        end
        if (i_cmd.list_clear) begin
            n_fill = '0;
            n_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_last   <= '0;
            r_j      <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_w      <= '0;
            r_e      <= '0;
            r_ovf    <= 1'b0;
            r_vld    <= 1'b0;
            r_efirst <= 1'b0;
            r_elast  <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_last   <= n_last;
            r_j      <= n_j;
            r_i      <= n_i;
            r_k      <= n_k;
            r_w      <= n_w;
            r_e      <= n_e;
            r_ovf    <= n_ovf;
            r_vld    <= n_vld;
            r_efirst <= n_efirst;
            r_elast  <= n_elast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_cur       <= n_cur;
        r_first_pos <= n_first_pos;
        r_end_pos   <= n_end_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_mixed <= EPS_RESET;
            r_eps_side  <= EPS_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_EPS_MIXED: r_eps_mixed <= i_cfg_data;
                CFG_EPS_SIDE:  r_eps_side  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_strobe                = r_vld;
    assign o_result.point_position = r_elast  ? r_end_pos   :
                                     r_efirst ? r_first_pos : r_rd.pos;
    assign o_result.point_kind     = r_rd.kind;
    assign o_result.last_out       = r_elast;
    assign o_result.segment_count  = SEG_W'(r_w);
    assign o_result.overflow       = r_ovf;

    a_survivors_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.merge_flush || i_cmd.emit_rd) |-> (r_w <= r_last))
        else $error("Survivor count exceeds the list length.");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_step |-> (r_w < r_k))
        else $error("Merge write index caught up with the scan index.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST_SLOT)
        else $error("Fill count passed the last slot.");

endmodule

`default_nettype wire
